FILE: rtl/wcs_pkg.sv
package wcs_pkg;

  localparam int CHANNELS   = 6;
  localparam int CHAN_W     = 8;
  localparam int COORD_W    = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CH_IDX_W   = 3;
  localparam int COUNT_W    = 25;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 40;
  localparam int MEAN_W     = 16;
  localparam int DEV_W      = 15;
  localparam int VAR_W      = 30;
  localparam int STEP_W     = 5;

  // Iteration counts of the shared arithmetic unit.
  localparam int MUL_STEPS  = 4;
  localparam int VAR_STEPS  = 30;
  localparam int MEAN_STEPS = 16;
  localparam int ROOT_STEPS = 15;

  localparam logic [CFG_W-1:0]   COORD_LIMIT = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_CAP   = 25'd16777216;

  localparam logic [CFG_IDX_W-1:0] REG_COL_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_HIGH = 3'd3;

  typedef struct packed {
    logic                             hit;
    logic                             last;
    logic [CHANNELS-1:0][CHAN_W-1:0]  chan;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] n;
    logic [SUM_W-1:0]   s;
    logic [SQ_W-1:0]    q;
  } stat_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] mean;
    logic [DEV_W-1:0]  dev;
  } stat_rsp_t;

endpackage

FILE: rtl/wcs_front.sv
module wcs_front
  import wcs_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  input  logic [COORD_W-1:0]              pixel_col,
  input  logic [COORD_W-1:0]              pixel_row,
  input  logic [CHANNELS-1:0][CHAN_W-1:0] chan,
  input  logic                            frame_end,
  output item_t                           item
);

  logic [CFG_W-1:0] col_low_r, col_high_r, row_low_r, row_high_r;
  logic [CFG_W-1:0] col_x, row_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_low_r  <= '0;
      col_high_r <= COORD_LIMIT;
      row_low_r  <= '0;
      row_high_r <= COORD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COL_LOW:  col_low_r  <= cfg_data;
        REG_COL_HIGH: col_high_r <= cfg_data;
        REG_ROW_LOW:  row_low_r  <= cfg_data;
        REG_ROW_HIGH: row_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign col_x = {1'b0, pixel_col};
  assign row_x = {1'b0, pixel_row};

  assign item.hit  = (col_x >= col_low_r) && (col_x < col_high_r) &&
                     (row_x >= row_low_r) && (row_x < row_high_r);
  assign item.last = frame_end;
  assign item.chan = chan;

endmodule

FILE: rtl/wcs_queue.sv
module wcs_queue
  import wcs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/wcs_stat.sv
module wcs_stat
  import wcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stat_req_t req,
  output stat_rsp_t rsp
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_LDV  = 7'b0000100,
    S_DIVV = 7'b0001000,
    S_DIVM = 7'b0010000,
    S_SQRT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [COUNT_W-1:0]  n_r;
  logic [SUM_W-1:0]    s_r;
  logic [SQ_W-1:0]     q_r;
  logic [63:0]         prod_r, acc_r;
  logic [48:0]         den_r;
  logic [47:0]         rem_r;
  logic [VAR_W-1:0]    sh_r, var_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [DEV_W-1:0]    root_r;
  logic [16:0]         sqrem_r;

  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod;
  logic [48:0]         div_t;
  logic                div_ge;
  logic [47:0]         rem_nxt;
  logic [VAR_W-1:0]    sh_nxt;
  logic [18:0]         sq_t, sq_trial;
  logic                sq_ge;
  logic [16:0]         sqrem_nxt;
  logic [DEV_W-1:0]    root_nxt;

  // One shared multiplier, fed in turn with the four partial products.
  always_comb begin
    case (cnt_r)
      5'd0: begin
        mul_a = 32'(n_r);
        mul_b = 32'(q_r[19:0]);
      end
      5'd1: begin
        mul_a = 32'(n_r);
        mul_b = 32'(q_r[39:20]);
      end
      5'd2: begin
        mul_a = s_r;
        mul_b = s_r;
      end
      default: begin
        mul_a = 32'(n_r);
        mul_b = 32'(n_r);
      end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // Restoring division step, one quotient bit per cycle.
  assign div_t   = {rem_r, sh_r[VAR_W-1]};
  assign div_ge  = (div_t >= den_r);
  assign rem_nxt = div_ge ? 48'(div_t - den_r) : div_t[47:0];
  assign sh_nxt  = {sh_r[VAR_W-2:0], div_ge};

  // Square root step, one root bit per cycle.
  assign sq_t      = {sqrem_r, sh_r[VAR_W-1:VAR_W-2]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = (sq_t >= sq_trial);
  assign sqrem_nxt = sq_ge ? 17'(sq_t - sq_trial) : sq_t[16:0];
  assign root_nxt  = {root_r[DEV_W-2:0], sq_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            n_r   <= req.n;
            s_r   <= req.s;
            q_r   <= req.q;
            cnt_r <= '0;
            if (req.n == '0) begin
              mean_r  <= '0;
              root_r  <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= prod;
          cnt_r  <= cnt_r + 1'b1;
          case (cnt_r)
            5'd1:    acc_r <= prod_r;
            5'd2:    acc_r <= acc_r + {prod_r[43:0], 20'b0};
            5'd3:    acc_r <= acc_r - prod_r;
            default: ;
          endcase
          if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
            state_r <= S_LDV;
          end
        end
        S_LDV: begin
          // The variance numerator is d * 2^16 over n^2.
          den_r   <= prod_r[48:0];
          rem_r   <= acc_r[61:14];
          sh_r    <= {acc_r[13:0], 16'b0};
          cnt_r   <= '0;
          state_r <= S_DIVV;
        end
        S_DIVV: begin
          if (cnt_r == STEP_W'(VAR_STEPS - 1)) begin
            var_r   <= sh_nxt;
            rem_r   <= {24'b0, s_r[31:8]};
            den_r   <= {24'b0, n_r};
            sh_r    <= {s_r[7:0], 22'b0};
            cnt_r   <= '0;
            state_r <= S_DIVM;
          end else begin
            rem_r <= rem_nxt;
            sh_r  <= sh_nxt;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIVM: begin
          if (cnt_r == STEP_W'(MEAN_STEPS - 1)) begin
            mean_r  <= sh_nxt[MEAN_W-1:0];
            sh_r    <= var_r;
            sqrem_r <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            rem_r <= rem_nxt;
            sh_r  <= sh_nxt;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SQRT: begin
          sh_r    <= {sh_r[VAR_W-3:0], 2'b00};
          sqrem_r <= sqrem_nxt;
          root_r  <= root_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == STEP_W'(ROOT_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == S_DONE);
  assign rsp.mean = mean_r;
  assign rsp.dev  = root_r;

endmodule

FILE: rtl/wcs_accum.sv
module wcs_accum
  import wcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  item_t               head,
  input  logic                empty,
  output logic                pop,
  output stat_req_t           req,
  input  stat_rsp_t           rsp,
  output logic                out_valid,
  output logic [CH_IDX_W-1:0] out_channel_index,
  output logic [COUNT_W-1:0]  out_pixel_count,
  output logic [MEAN_W-1:0]   out_mean_q8,
  output logic [DEV_W-1:0]    out_stddev_q8,
  output logic [CHAN_W-1:0]   out_low_value,
  output logic [CHAN_W-1:0]   out_high_value,
  output logic                out_window_empty,
  output logic                out_run_last
);

  typedef enum logic [2:0] {
    S_ACC   = 3'b001,
    S_START = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t                           state_r;
  logic [CH_IDX_W-1:0]              ch_r;
  logic [COUNT_W-1:0]               count_r;
  logic [CHANNELS-1:0][SUM_W-1:0]   sum_r;
  logic [CHANNELS-1:0][SQ_W-1:0]    sq_r;
  logic [CHANNELS-1:0][CHAN_W-1:0]  min_r, max_r;
  logic                             valid_r;
  logic [CH_IDX_W-1:0]              idx_r;
  logic [COUNT_W-1:0]               cnt_out_r;
  logic [MEAN_W-1:0]                mean_r;
  logic [DEV_W-1:0]                 dev_r;
  logic [CHAN_W-1:0]                low_r, high_r;
  logic                             empty_r, last_r;

  assign pop = (state_r == S_ACC) && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      ch_r    <= '0;
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= '1;
      max_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (state_r == S_WAIT) && rsp.done;
      unique case (state_r)
        S_ACC: begin
          if (pop) begin
            if (head.hit && (count_r < COUNT_CAP)) begin
              count_r <= count_r + 1'b1;
              for (int c = 0; c < CHANNELS; c++) begin
                sum_r[c] <= sum_r[c] + SUM_W'(head.chan[c]);
                sq_r[c]  <= sq_r[c] + SQ_W'(16'(head.chan[c]) * 16'(head.chan[c]));
                if (head.chan[c] < min_r[c]) min_r[c] <= head.chan[c];
                if (head.chan[c] > max_r[c]) max_r[c] <= head.chan[c];
              end
            end
            if (head.last) begin
              ch_r    <= '0;
              state_r <= S_START;
            end
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            idx_r     <= ch_r;
            cnt_out_r <= count_r;
            mean_r    <= rsp.mean;
            dev_r     <= rsp.dev;
            low_r     <= min_r[ch_r];
            high_r    <= max_r[ch_r];
            empty_r   <= (count_r == '0);
            last_r    <= (ch_r == CH_IDX_W'(CHANNELS - 1));
            if (ch_r == CH_IDX_W'(CHANNELS - 1)) begin
              count_r <= '0;
              sum_r   <= '0;
              sq_r    <= '0;
              min_r   <= '1;
              max_r   <= '0;
              state_r <= S_ACC;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign req.start = (state_r == S_START);
  assign req.n     = count_r;
  assign req.s     = sum_r[ch_r];
  assign req.q     = sq_r[ch_r];

  assign out_valid         = valid_r;
  assign out_channel_index = idx_r;
  assign out_pixel_count   = cnt_out_r;
  assign out_mean_q8       = mean_r;
  assign out_stddev_q8     = dev_r;
  assign out_low_value     = low_r;
  assign out_high_value    = high_r;
  assign out_window_empty  = empty_r;
  assign out_run_last      = last_r;

endmodule

FILE: rtl/window_channel_statistics.sv
// Latency: a pixel is accumulated at the edge after its transfer when the queue is
// empty; otherwise it waits behind queued pixels and any frame still being closed.
// After a frame-end pixel, each channel in turn goes through the shared stat unit
// (multiply, load, variance divide, mean divide, root; skipped for an empty window).
// Throughput: one pixel per cycle; busy rises once QUEUE_DEPTH pixels wait.
// Results are single-cycle strobes on out_valid; the receiver cannot stall them.
// Reset (rst_n low, synchronous) restores the full window and clears all sums.
module window_channel_statistics
  import wcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_pixel_col,
  input  logic [COORD_W-1:0]   in_pixel_row,
  input  logic [CHAN_W-1:0]    in_chan_zero,
  input  logic [CHAN_W-1:0]    in_chan_one,
  input  logic [CHAN_W-1:0]    in_chan_two,
  input  logic [CHAN_W-1:0]    in_chan_three,
  input  logic [CHAN_W-1:0]    in_chan_four,
  input  logic [CHAN_W-1:0]    in_chan_five,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  output logic [CH_IDX_W-1:0]  out_channel_index,
  output logic [COUNT_W-1:0]   out_pixel_count,
  output logic [MEAN_W-1:0]    out_mean_q8,
  output logic [DEV_W-1:0]     out_stddev_q8,
  output logic [CHAN_W-1:0]    out_low_value,
  output logic [CHAN_W-1:0]    out_high_value,
  output logic                 out_window_empty,
  output logic                 out_run_last
);

  logic [CHANNELS-1:0][CHAN_W-1:0] chan;
  item_t                           in_item, head;
  logic                            q_empty, q_full, pop;
  stat_req_t                       req;
  stat_rsp_t                       rsp;

  assign chan = {in_chan_five, in_chan_four, in_chan_three,
                 in_chan_two, in_chan_one, in_chan_zero};

  // A transfer happens when start is high and the queue has room.
  assign busy = q_full;

  // The front end holds the window registers and tags each pixel as inside or not.
  wcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_col (in_pixel_col),
    .pixel_row (in_pixel_row),
    .chan      (chan),
    .frame_end (in_frame_end),
    .item      (in_item)
  );

  // The queue lets pixels keep arriving while the back end is busy.
  wcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_item (in_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end accumulates, then walks the channels through the stat unit.
  wcs_accum u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .empty             (q_empty),
    .pop               (pop),
    .req               (req),
    .rsp               (rsp),
    .out_valid         (out_valid),
    .out_channel_index (out_channel_index),
    .out_pixel_count   (out_pixel_count),
    .out_mean_q8       (out_mean_q8),
    .out_stddev_q8     (out_stddev_q8),
    .out_low_value     (out_low_value),
    .out_high_value    (out_high_value),
    .out_window_empty  (out_window_empty),
    .out_run_last      (out_run_last)
  );

  wcs_stat u_stat (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule
